FILE: sv/bmchd_pkg.sv
// bmchd_pkg: shared widths, timer constants, phase encoding and register
// indexes for the button multi-click / hold detector. No dependencies.

package bmchd_pkg;

	// Width of the elapsed-time counter (range 8 to 32).
	localparam int TIMER_BITS = 16;
	// Width of millisecond fields and threshold registers.
	localparam int MS_BITS    = 16;
	// Compare width covers both the timer and a threshold.
	localparam int CMP_BITS   = (TIMER_BITS > MS_BITS) ? TIMER_BITS : MS_BITS;
	// One spare bit holds the carry of timer + elapsed.
	localparam int SUM_BITS   = CMP_BITS + 1;
	localparam int COUNT_BITS = 4;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [SUM_BITS-1:0] TIMER_MAX =
		{{(SUM_BITS - TIMER_BITS){1'b0}}, {TIMER_BITS{1'b1}}};

	typedef enum logic [2:0] {
		PH_AWAIT_PRESS   = 3'd0,
		PH_DEB_PRESS     = 3'd1,
		PH_AWAIT_RELEASE = 3'd2,
		PH_DEB_RELEASE   = 3'd3,
		PH_AWAIT_MULTI   = 3'd4
	} phase_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_LEVEL  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PRESS_DEB     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE_DEB   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD          = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLICK_GAP     = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLICK_LIMIT   = 3'd5;

	// Register reset values.
	localparam logic [MS_BITS-1:0]    RST_PRESS_DEB   = 16'd50;
	localparam logic [MS_BITS-1:0]    RST_RELEASE_DEB = 16'd50;
	localparam logic [MS_BITS-1:0]    RST_HOLD        = 16'd1000;
	localparam logic [MS_BITS-1:0]    RST_CLICK_GAP   = 16'd300;
	localparam logic [COUNT_BITS-1:0] RST_CLICK_LIMIT = 4'd5;

endpackage

FILE: sv/button_multi_click_hold_detector.sv
// button_multi_click_hold_detector: debounced push-button event detector
// (multi-click count and repeating long hold). Depends on bmchd_pkg.
//
// Each input beat is one update tick: the sampled pin level and the
// milliseconds since the previous tick. The block takes one tick per clock
// cycle while no result sits stalled at the output. A tick is captured into
// the input register, and once the output slot can advance a single pass of
// logic (one saturating add, a few 16-bit compares and the five-phase state
// machine) updates the state and, when an event finishes, loads the output
// register, which drives out_valid, click_count and held. Per tick at most
// one result beat comes out: held=1 with click_count=0 for a hold (repeating
// every hold_ms while pressed), or held=0 with the click count once the
// click gap expires. A release after a hold gives nothing. The output
// register and the input register form two slots, so a new tick is still
// taken while a result waits under out_stall; in_stall rises only when both
// slots are full. All time tests are strict greater-than against a timer
// that saturates at its maximum. Configuration writes (cfg_wr_en, cfg_index,
// cfg_wdata) take effect at once and belong to idle periods; indexes past
// the last register are ignored.

module button_multi_click_hold_detector (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_wr_en,
	input  logic [bmchd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [bmchd_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	// tick input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                pin_level,
	input  logic [bmchd_pkg::MS_BITS-1:0]       elapsed_ms,
	// event output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bmchd_pkg::COUNT_BITS-1:0]    click_count,
	output logic                                held
);
	import bmchd_pkg::*;

	// configuration registers
	logic                  active_level_q;
	logic [MS_BITS-1:0]    press_deb_q;
	logic [MS_BITS-1:0]    release_deb_q;
	logic [MS_BITS-1:0]    hold_q;
	logic [MS_BITS-1:0]    click_gap_q;
	logic [COUNT_BITS-1:0] click_limit_q;

	// input register
	logic               valid_s1;
	logic               pin_s1;
	logic [MS_BITS-1:0] elapsed_s1;

	// detector state
	phase_t                phase_q, phase_d;
	logic [TIMER_BITS-1:0] timer_q, timer_d;
	logic [COUNT_BITS-1:0] clicks_q, clicks_d;
	logic                  hold_seen_q, hold_seen_d;

	// output register
	logic                  out_valid_q;
	logic [COUNT_BITS-1:0] click_count_q;
	logic                  held_q;

	// datapath
	logic                  advance;
	logic                  step;
	logic                  pressed;
	logic [SUM_BITS-1:0]   sum;
	logic [SUM_BITS-1:0]   sum_sat;
	logic [CMP_BITS-1:0]   t_cmp;
	logic [COUNT_BITS-1:0] limit_eff;
	logic [COUNT_BITS:0]   clicks_inc;
	logic [COUNT_BITS-1:0] clicks_next;
	logic                  res_valid;
	logic [COUNT_BITS-1:0] res_count;
	logic                  res_held;

	// Output slot can take a new value unless a result sits stalled in it.
	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	assign out_valid   = out_valid_q;
	assign click_count = click_count_q;
	assign held        = held_q;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_level_q <= 1'b0;
			press_deb_q    <= RST_PRESS_DEB;
			release_deb_q  <= RST_RELEASE_DEB;
			hold_q         <= RST_HOLD;
			click_gap_q    <= RST_CLICK_GAP;
			click_limit_q  <= RST_CLICK_LIMIT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ACTIVE_LEVEL: active_level_q <= cfg_wdata[0];
				CFG_PRESS_DEB:    press_deb_q    <= cfg_wdata[MS_BITS-1:0];
				CFG_RELEASE_DEB:  release_deb_q  <= cfg_wdata[MS_BITS-1:0];
				CFG_HOLD:         hold_q         <= cfg_wdata[MS_BITS-1:0];
				CFG_CLICK_GAP:    click_gap_q    <= cfg_wdata[MS_BITS-1:0];
				CFG_CLICK_LIMIT:  click_limit_q  <= cfg_wdata[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- input register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pin_s1     <= pin_level;
			elapsed_s1 <= elapsed_ms;
		end
	end

	// ---------------- timer and click arithmetic ----------------
	assign pressed = (pin_s1 == active_level_q);
	assign sum     = SUM_BITS'(timer_q) + SUM_BITS'(elapsed_s1);
	assign sum_sat = (sum > TIMER_MAX) ? TIMER_MAX : sum;
	assign t_cmp   = sum_sat[CMP_BITS-1:0];

	// A zero limit counts as one.
	assign limit_eff   = (click_limit_q == '0) ? COUNT_BITS'(1) : click_limit_q;
	assign clicks_inc  = {1'b0, clicks_q} + (COUNT_BITS+1)'(1);
	assign clicks_next = (clicks_inc > {1'b0, limit_eff}) ? limit_eff
	                                                      : clicks_inc[COUNT_BITS-1:0];

	// ---------------- phase machine ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_AWAIT_PRESS;
			timer_q     <= '0;
			clicks_q    <= '0;
			hold_seen_q <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			timer_q     <= timer_d;
			clicks_q    <= clicks_d;
			hold_seen_q <= hold_seen_d;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		timer_d     = sum_sat[TIMER_BITS-1:0];
		clicks_d    = clicks_q;
		hold_seen_d = hold_seen_q;
		res_valid   = 1'b0;
		res_count   = '0;
		res_held    = 1'b0;
		case (phase_q)
			PH_DEB_PRESS: begin
				if (t_cmp > CMP_BITS'(press_deb_q)) begin
					phase_d = PH_AWAIT_RELEASE;
					timer_d = '0;
				end
			end
			PH_AWAIT_RELEASE: begin
				if (!pressed) begin
					phase_d = PH_DEB_RELEASE;
					timer_d = '0;
				end else if (t_cmp > CMP_BITS'(hold_q)) begin
					// hold event, repeats while still pressed
					hold_seen_d = 1'b1;
					timer_d     = '0;
					res_valid   = 1'b1;
					res_held    = 1'b1;
				end
			end
			PH_DEB_RELEASE: begin
				if (t_cmp > CMP_BITS'(release_deb_q)) begin
					if (hold_seen_q) begin
						// release after hold: timer keeps running
						phase_d = PH_AWAIT_PRESS;
					end else begin
						clicks_d = clicks_next;
						phase_d  = PH_AWAIT_MULTI;
						timer_d  = '0;
					end
				end
			end
			PH_AWAIT_MULTI: begin
				if (pressed) begin
					phase_d = PH_DEB_PRESS;
					timer_d = '0;
				end else if (t_cmp > CMP_BITS'(click_gap_q)) begin
					phase_d   = PH_AWAIT_PRESS;
					res_valid = 1'b1;
					res_count = clicks_q;
				end
			end
			default: begin
				// await press, and any unused code
				clicks_d    = '0;
				hold_seen_d = 1'b0;
				phase_d     = PH_AWAIT_PRESS;
				if (pressed) begin
					phase_d = PH_DEB_PRESS;
					timer_d = '0;
				end
			end
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			click_count_q <= res_count;
			held_q        <= res_held;
		end
	end

	// ---------------- assertions ----------------
	a_hold_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && held |-> click_count == '0)
		else $error("hold event with nonzero click count");

	a_click_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !held |-> click_count != '0)
		else $error("click sequence reported with zero clicks");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled while a slot is free");

endmodule
